>>> rtl/core/route_longest_prefix_match_macros.svh
// assertion macros for the route_longest_prefix_match checker
`ifndef ROUTE_LONGEST_PREFIX_MATCH_MACROS_SVH
`define ROUTE_LONGEST_PREFIX_MATCH_MACROS_SVH

// same-cycle implication under reset
`define RLPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define RLPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rlpm_pkg.sv
// shared types and constants for the longest prefix match table
`timescale 1ns / 1ps

package rlpm_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int PORTS_DEF   = 16;

  localparam int IDX_W       = 4;
  localparam int PORT_W      = 4;
  localparam int ADDR_W      = 32;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              vld;
    func_t             func;
    logic              wr_en;
    logic [IDX_W-1:0]  slot_index;
    logic              slot_valid;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [ADDR_W-1:0] best_mask;
    logic [IDX_W-1:0]  best_idx;
    logic [PORT_W-1:0] best_port;
  } tok_t;

endpackage

>>> rtl/core/route_longest_prefix_match.sv
// IPv4 longest prefix match routing table built as a chain of slot cells
// Every beat, write or lookup, passes the token registers of the chain of ENTRIES cells in
// order, so each slot sees beats in arrival order. A lookup result appears in the output
// register after the beat leaves the last cell; a write gives no result. One beat is accepted
// per cycle while the output register is free or being read, so the stall of the whole chain
// is set by the output handshake. The 4-bit slot index reaches slots 0 to 15 only; a write
// with a port number of PORTS or above is dropped. Valid marks clear at reset; no clearing pass.
`timescale 1ns / 1ps

module route_longest_prefix_match #(
  parameter int ENTRIES = rlpm_pkg::ENTRIES_DEF,
  parameter int PORTS   = rlpm_pkg::PORTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // slot_index, slot_valid, slot_dest, slot_mask, slot_port, lookup_addr, zero pad
  input  logic [rlpm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_port, match_index, match_mask
  output logic [rlpm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // hit
  output logic                                out_tuser
);

  rlpm_pkg::tok_t tok [0:ENTRIES];
  rlpm_pkg::tok_t tok_last;
  logic           adv;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           out_hit_r;
  logic [rlpm_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    tok[0]            = '0;
    tok[0].vld        = in_tvalid;
    tok[0].func       = rlpm_pkg::func_t'(in_tuser);
    tok[0].slot_index = in_tdata[3:0];
    tok[0].slot_valid = in_tdata[4];
    tok[0].dest       = in_tdata[36:5];
    tok[0].mask       = in_tdata[68:37];
    tok[0].port       = in_tdata[72:69];
    tok[0].addr       = in_tdata[104:73];
    tok[0].wr_en      = (32'(in_tdata[72:69]) < 32'(PORTS));
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rlpm_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .tok_in (tok[g]),
      .tok_out(tok[g+1])
    );
  end

  assign tok_last = tok[ENTRIES];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = tok_last.vld && (tok_last.func == rlpm_pkg::FUNC_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r  <= tok_last.found;
      out_data_r <= {tok_last.best_mask, tok_last.best_idx, tok_last.best_port};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

endmodule

>>> rtl/core/rlpm_cell.sv
// one table slot with its compare logic and token register
`timescale 1ns / 1ps

module rlpm_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  rlpm_pkg::tok_t tok_in,
  output rlpm_pkg::tok_t tok_out
);

  logic [rlpm_pkg::ADDR_W-1:0] dest_r;
  logic [rlpm_pkg::ADDR_W-1:0] mask_r;
  logic [rlpm_pkg::PORT_W-1:0] port_r;
  logic                        valid_r;
  logic                        valid_nxt;
  logic                        vld_r;
  rlpm_pkg::tok_t              pay_r;
  rlpm_pkg::tok_t              tok_nxt;
  logic                        wr_hit;
  logic                        match;
  logic                        take;

  assign wr_hit = tok_in.vld && (tok_in.func == rlpm_pkg::FUNC_WRITE) && tok_in.wr_en &&
                  ({28'd0, tok_in.slot_index} == 32'(CELL_IDX));

  assign match = valid_r && ((tok_in.addr & mask_r) == (dest_r & mask_r));

  assign take = tok_in.vld && (tok_in.func == rlpm_pkg::FUNC_LOOKUP) && match &&
                (!tok_in.found || (mask_r > tok_in.best_mask));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_mask = mask_r;
      tok_nxt.best_idx  = rlpm_pkg::IDX_W'(CELL_IDX);
      tok_nxt.best_port = port_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (adv && wr_hit) begin
      valid_nxt = tok_in.slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (adv) begin
        vld_r <= tok_in.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_hit) begin
      dest_r <= tok_in.dest;
      mask_r <= tok_in.mask;
      port_r <= tok_in.port;
    end
    if (adv) begin
      pay_r <= tok_nxt;
    end
  end

  always_comb begin
    tok_out     = pay_r;
    tok_out.vld = vld_r;
  end

endmodule

>>> rtl/core/rlpm_checker.sv
// port-level checks for route_longest_prefix_match, bound to the top level
`timescale 1ns / 1ps
`include "route_longest_prefix_match_macros.svh"

module rlpm_checker #(
  parameter int PORTS = rlpm_pkg::PORTS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [rlpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rlpm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  // stalled result beat holds
  `RLPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // a miss carries all-zero data
  `RLPM_ASSERT_NOW(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0, "miss with nonzero data")

  // a hit names a port that could have been written
  `RLPM_ASSERT_NOW(a_hit_port, clk, rst_n, out_tvalid && out_tuser, 32'(out_tdata[3:0]) < 32'(PORTS), "hit with out of range port")

  // a stalled output freezes the chain
  `RLPM_ASSERT_NOW(a_stall_in, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")

endmodule

bind route_longest_prefix_match rlpm_checker #(.PORTS(PORTS)) u_rlpm_checker (.*);
